// ===== sv/solid_color_texture_block_encoder_top_assert.svh =====
`ifndef SOLID_COLOR_TEXTURE_BLOCK_ENCODER_TOP_ASSERT_SVH
`define SOLID_COLOR_TEXTURE_BLOCK_ENCODER_TOP_ASSERT_SVH

// same-cycle implication
`define SCTBE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sctbe assertion failed");

// next-cycle implication
`define SCTBE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sctbe assertion failed");

`endif

// ===== sv/sctbe_pkg.sv =====
package sctbe_pkg;

   localparam int ColorW   = 32;
   localparam int BlockW   = 64;
   localparam int NumCand  = 32;
   localparam int CandW    = $clog2(NumCand);
   localparam int ScoreW   = 10;
   localparam int ModW     = 10;

   localparam logic [7:0] RoundBias = 8'd128;
   localparam logic [7:0] ChanMax   = 8'd255;
   localparam logic [2:0] DiffZero  = 3'b000;

   typedef enum logic {
      FMT_ETC1 = 1'b0,
      FMT_BC1  = 1'b1
   } block_format_type;

   typedef logic [7:0] mod_row_type [8];

   localparam mod_row_type ModSmall = '{8'd2, 8'd5, 8'd9, 8'd13, 8'd18, 8'd24, 8'd33, 8'd47};
   localparam mod_row_type ModLarge = '{8'd8, 8'd17, 8'd29, 8'd42, 8'd60, 8'd80, 8'd106, 8'd183};

   typedef struct packed {
      block_format_type                     fmt;
      logic [ColorW-1:0]                    color;
      logic [4:0]                           r5;
      logic [4:0]                           g5;
      logic [4:0]                           b5;
      logic [5:0]                           g6;
      logic [NumCand-1:0][ScoreW-1:0]       score;
   } cand_type;

   function automatic logic [4:0] quant5(input logic [7:0] c);
      logic [12:0] p;
      logic [12:0] s;
      p = (13'(c) << 5) - 13'(c) + 13'(RoundBias);
      s = p + (p >> 8);
      return s[12:8];
   endfunction

   function automatic logic [5:0] quant6(input logic [7:0] c);
      logic [13:0] p;
      logic [13:0] s;
      p = (14'(c) << 6) - 14'(c) + 14'(RoundBias);
      s = p + (p >> 8);
      return s[13:8];
   endfunction

   function automatic logic signed [ModW-1:0] mod_value(input logic [CandW-1:0] cand);
      logic [7:0] mag;
      mag = cand[0] ? ModLarge[cand[4:2]] : ModSmall[cand[4:2]];
      return cand[1] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
   endfunction

   function automatic logic [7:0] chan_err(input logic [7:0] orig, input logic [7:0] ext,
                                           input logic signed [ModW-1:0] m);
      logic signed [ModW:0] sum;
      logic [7:0]           clamped;
      sum = $signed({3'b000, ext}) + $signed({m[ModW-1], m});
      priority if (sum < 0) begin
         clamped = 8'd0;
      end else if (sum > $signed({3'b000, ChanMax})) begin
         clamped = ChanMax;
      end else begin
         clamped = sum[7:0];
      end
      return (orig > clamped) ? orig - clamped : clamped - orig;
   endfunction

endpackage

// ===== sv/sctbe_front.sv =====
module sctbe_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [sctbe_pkg::ColorW-1:0] in_color,
   input  sctbe_pkg::block_format_type in_fmt,
   output logic                       out_valid,
   output sctbe_pkg::cand_type        out_cand
);
   import sctbe_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [ColorW-1:0] s1_color_ff;
   block_format_type  s1_fmt_ff;
   logic              s2_valid_ff, s2_valid_in;
   cand_type          s2_cand_ff, s2_cand_in;

   always_comb begin
      logic [7:0] r8, g8, b8, re, ge, be;
      logic signed [ModW-1:0] m;
      r8 = s1_color_ff[23:16];
      g8 = s1_color_ff[15:8];
      b8 = s1_color_ff[7:0];
      s2_cand_in.fmt   = s1_fmt_ff;
      s2_cand_in.color = s1_color_ff;
      s2_cand_in.r5    = quant5(r8);
      s2_cand_in.g5    = quant5(g8);
      s2_cand_in.b5    = quant5(b8);
      s2_cand_in.g6    = quant6(g8);
      re = {s2_cand_in.r5, s2_cand_in.r5[4:2]};
      ge = {s2_cand_in.g5, s2_cand_in.g5[4:2]};
      be = {s2_cand_in.b5, s2_cand_in.b5[4:2]};
      for (int c = 0; c < NumCand; c++) begin
         m = mod_value(CandW'(c));
         s2_cand_in.score[c] = {2'b00, chan_err(r8, re, m)} + {2'b00, chan_err(g8, ge, m)}
                             + {2'b00, chan_err(b8, be, m)};
      end
   end

   assign s1_valid_in = adv ? in_valid : s1_valid_ff;
   assign s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_color_ff <= in_color;
         s1_fmt_ff   <= in_fmt;
         s2_cand_ff  <= s2_cand_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_cand  = s2_cand_ff;

endmodule

// ===== sv/sctbe_select.sv =====
module sctbe_select (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  sctbe_pkg::cand_type          in_cand,
   output logic                         out_valid,
   output logic [sctbe_pkg::BlockW-1:0] out_block
);
   import sctbe_pkg::*;

   `include "solid_color_texture_block_encoder_top_assert.svh"

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BlockW-1:0] rsp_block_ff, rsp_block_in;

   logic [ScoreW-1:0] node_score [1:2*NumCand-1];
   logic [CandW-1:0]  node_idx   [1:2*NumCand-1];
   logic [CandW-1:0]  best;
   logic [31:0]       etc_high;
   logic [15:0]       bc_color;
   logic [63:0]       etc_block, bc_block;

   always_comb begin
      for (int n = 0; n < NumCand; n++) begin
         node_score[NumCand+n] = in_cand.score[n];
         node_idx[NumCand+n]   = CandW'(n);
      end
      for (int n = NumCand - 1; n >= 1; n--) begin
         if (node_score[2*n+1] < node_score[2*n]) begin
            node_score[n] = node_score[2*n+1];
            node_idx[n]   = node_idx[2*n+1];
         end else begin
            node_score[n] = node_score[2*n];
            node_idx[n]   = node_idx[2*n];
         end
      end
   end

   assign best     = node_idx[1];
   assign etc_high = {in_cand.r5, DiffZero, in_cand.g5, DiffZero, in_cand.b5, DiffZero,
                      best[4:2], best[4:2], 1'b1, 1'b0};
   assign etc_block = {{16{best[0]}}, {16{best[1]}},
                       etc_high[7:0], etc_high[15:8], etc_high[23:16], etc_high[31:24]};
   assign bc_color  = {in_cand.r5, in_cand.g6, in_cand.b5};
   assign bc_block  = {{32{~|in_cand.color}}, bc_color, bc_color};

   always_comb begin
      unique case (in_cand.fmt)
         FMT_ETC1: rsp_block_in = etc_block;
         FMT_BC1:  rsp_block_in = bc_block;
         default:  rsp_block_in = etc_block;
      endcase
   end

   assign rsp_valid_in = adv ? in_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         rsp_block_ff <= rsp_block_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_block = rsp_block_ff;

   `SCTBE_ASSERT_NEXT(a_etc_code, clock, reset, adv && in_valid && in_cand.fmt == FMT_ETC1,
      rsp_block_ff[25] && !rsp_block_ff[24] && rsp_block_ff[31:29] == rsp_block_ff[28:26])
   `SCTBE_ASSERT_NEXT(a_etc_idx, clock, reset, adv && in_valid && in_cand.fmt == FMT_ETC1,
      (&rsp_block_ff[47:32] || ~|rsp_block_ff[47:32]) && (&rsp_block_ff[63:48] || ~|rsp_block_ff[63:48]))
   `SCTBE_ASSERT_NEXT(a_bc_ends, clock, reset, adv && in_valid && in_cand.fmt == FMT_BC1,
      rsp_block_ff[15:0] == rsp_block_ff[31:16])

endmodule

// ===== sv/solid_color_texture_block_encoder_top.sv =====
// Solid-color 4x4 block encoder: one ARGB color in, one 8-byte compressed block out.
// req_*: input stream, one color per transfer (tdata = fill_color).
// rsp_*: result stream, one block per transfer (tdata = block_bytes, byte 0 in bits 7:0).
// csr_*: one-bit format register, 0 = ETC1 differential block, 1 = BC1 block; always ready.
//   The format is sampled with each color as it is taken, so write it only while idle.
// Throughput: one block per cycle, with a new color taken in every cycle while the
//   result side is free or being drained.
// Pipeline: 3 register stages (input, candidate scores, result); a color taken passes
//   through them in that order, and its block is then offered on rsp.
// The 32 ETC1 modifier candidates are scored in parallel in the second stage and the
//   best is picked by a tree compare in the third, so a new color can be taken every cycle unless rsp stalls.
// Reset clears all valid flags and selects ETC1; no clearing pass is needed.
// When rsp_tready is low with a block pending, the whole pipeline holds and req_tready
//   drops in the same cycle; nothing is lost or repeated.
module solid_color_texture_block_encoder_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [sctbe_pkg::ColorW-1:0] req_tdata,   // [31:0] fill_color
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [sctbe_pkg::BlockW-1:0] rsp_tdata,   // [63:0] block_bytes
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_data
);
   import sctbe_pkg::*;

   `include "solid_color_texture_block_encoder_top_assert.svh"

   block_format_type fmt_ff, fmt_in;
   logic             adv;
   logic             cand_valid;
   cand_type         cand;

   assign csr_ready = 1'b1;
   assign fmt_in    = (csr_valid && csr_ready) ? block_format_type'(csr_data) : fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_ETC1;
      end else begin
         fmt_ff <= fmt_in;
      end
   end

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   sctbe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_color  (req_tdata),
      .in_fmt    (fmt_ff),
      .out_valid (cand_valid),
      .out_cand  (cand)
   );

   sctbe_select u_select (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cand_valid),
      .in_cand   (cand),
      .out_valid (rsp_tvalid),
      .out_block (rsp_tdata)
   );

   `SCTBE_ASSERT_NOW(a_stall_blocks_req, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `SCTBE_ASSERT_NEXT(a_csr_sets_fmt, clock, reset, csr_valid && csr_ready, fmt_ff == $past(csr_data))

endmodule

// ===== tb/solid_color_texture_block_encoder_top_test.sv =====
`timescale 1ns / 1ps

module solid_color_texture_block_encoder_top_test;
   import sctbe_pkg::*;

   localparam int CycleLimit = 300000;
   localparam int DrainLimit = 5000;
   localparam int SettleCycles = 8;
   localparam int HoldoffCycles = 300;
   localparam int ItemsPerPhase = 430;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ColorW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [BlockW-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_data = 1'b0;

   block_format_type active_format = FMT_ETC1;
   logic [ColorW-1:0] pending_colors [$];
   logic [BlockW-1:0] expected_blocks [$];
   logic [BlockW-1:0] block_want;
   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_requests = 0;

   int burst_left = 0;
   int gap_left = 0;
   int ready_cycle = 0;
   int ready_mode = 0;
   int hold_served = 0;
   int holdoff_left = 0;

   logic [ColorW-1:0] corner_colors [] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFF00_0000, 32'h00FF_0000,
      32'h0000_FF00, 32'h0000_00FF, 32'h0100_0000, 32'h0000_0001, 32'h8080_8080,
      32'h7F7F_7F7F, 32'h1234_5678, 32'h00FB_0404
   };

   solid_color_texture_block_encoder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   function automatic int scale_chan(input int mul, input int c);
      int p;
      p = mul * c + 128;
      return (p + (p >> 8)) >> 8;
   endfunction

   function automatic logic [31:0] swap_bytes(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   function automatic logic [BlockW-1:0] encode_fill_block(input logic [ColorW-1:0] color,
                                                          input block_format_type fmt);
      int orig [3];
      int ext [3];
      int q [3];
      int best_score;
      int best_t;
      int best_i;
      int score;
      int mag;
      int m;
      int v;
      int t;
      int i;
      int k;
      logic [31:0] hi;
      logic [31:0] lo;
      logic [15:0] rgb565;
      if (fmt == FMT_BC1) begin
         rgb565 = {5'(scale_chan(31, int'(color[23:16]))),
                   6'(scale_chan(63, int'(color[15:8]))),
                   5'(scale_chan(31, int'(color[7:0])))};
         hi = (color == '0) ? 32'hFFFF_FFFF : 32'h0000_0000;
         return {hi, rgb565, rgb565};
      end
      for (k = 0; k < 3; k++) begin
         orig[k] = int'((color >> (16 - 8 * k)) & 32'hFF);
         q[k] = scale_chan(31, orig[k]) & 31;
         ext[k] = (q[k] << 3) | (q[k] >> 2);
      end
      best_score = 1024;
      best_t = 0;
      best_i = 0;
      for (t = 0; t < 8; t++) begin
         for (i = 0; i < 4; i++) begin
            case (t)
               0: mag = (i & 1) ? 8 : 2;
               1: mag = (i & 1) ? 17 : 5;
               2: mag = (i & 1) ? 29 : 9;
               3: mag = (i & 1) ? 42 : 13;
               4: mag = (i & 1) ? 60 : 18;
               5: mag = (i & 1) ? 80 : 24;
               6: mag = (i & 1) ? 106 : 33;
               default: mag = (i & 1) ? 183 : 47;
            endcase
            m = (i & 2) ? -mag : mag;
            score = 0;
            for (k = 0; k < 3; k++) begin
               v = ext[k] + m;
               if (v < 0) begin
                  v = 0;
               end else if (v > 255) begin
                  v = 255;
               end
               score += (orig[k] > v) ? orig[k] - v : v - orig[k];
            end
            if (score < best_score) begin
               best_score = score;
               best_t = t;
               best_i = i;
            end
         end
      end
      hi = (32'(q[0]) << 27) | (32'(q[1]) << 19) | (32'(q[2]) << 11) | 32'h2 |
           (32'(best_t) << 5) | (32'(best_t) << 2);
      lo = 32'h0;
      if (best_i & 1) begin
         lo |= 32'h0000_FFFF;
      end
      if (best_i & 2) begin
         lo |= 32'hFFFF_0000;
      end
      return {swap_bytes(lo), swap_bytes(hi)};
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic write_block_format(input block_format_type fmt);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= fmt;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      active_format = fmt;
   endtask

   task automatic drain_pipeline();
      int waited;
      waited = 0;
      while (pending_colors.size() != 0 || req_tvalid) @(negedge clock);
      while (expected_blocks.size() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (SettleCycles) @(posedge clock);
      if (expected_blocks.size() != 0) begin
         report_mismatch($sformatf("%0d blocks never arrived", expected_blocks.size()));
         expected_blocks.delete();
      end
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // sender: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_blocks.push_back(encode_fill_block(req_tdata, active_format));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_colors.size() != 0) begin
               req_tdata <= pending_colors.pop_front();
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(0, 15);
                  gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern switches among four modes; long holdoff on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         ready_cycle++;
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            holdoff_left = HoldoffCycles;
         end
         if (ready_cycle % 97 == 0) begin
            ready_mode = $urandom_range(0, 3);
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (ready_cycle % 4) == 0;
               default: rsp_tready <= $urandom_range(0, 7) == 0;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_blocks.size() == 0) begin
            report_mismatch($sformatf("unexpected block %h", rsp_tdata));
         end else begin
            block_want = expected_blocks.pop_front();
            if (rsp_tdata !== block_want) begin
               report_mismatch($sformatf("block_bytes %h, want %h", rsp_tdata, block_want));
            end
         end
      end
   end

   initial begin
      int phase;
      int n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset format first, then the same corners in the other format
      foreach (corner_colors[j]) pending_colors.push_back(corner_colors[j]);
      drain_pipeline();
      write_block_format(FMT_BC1);
      foreach (corner_colors[j]) pending_colors.push_back(corner_colors[j]);
      drain_pipeline();

      for (phase = 0; phase < 4; phase++) begin
         write_block_format((phase % 2 != 0) ? FMT_BC1 : FMT_ETC1);
         if (phase % 2 != 0) begin
            hold_requests <= hold_requests + 1;
         end
         for (n = 0; n < ItemsPerPhase; n++) begin
            logic [ColorW-1:0] c;
            int k;
            int pick;
            c = $urandom;
            pick = $urandom_range(0, 7);
            if (pick == 0) begin
               c = '0;
            end else if (pick <= 2) begin
               for (k = 0; k < 4; k++) begin
                  case ($urandom_range(0, 2))
                     0: c[8*k +: 8] = 8'h00;
                     1: c[8*k +: 8] = 8'hFF;
                     default: ;
                  endcase
               end
            end else if (pick == 3) begin
               c[15:0] = {c[23:16], c[23:16]};
            end
            pending_colors.push_back(c);
         end
         drain_pipeline();
      end

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== solid_color_texture_block_encoder_top.f =====
+incdir+sv
sv/sctbe_pkg.sv
sv/sctbe_front.sv
sv/sctbe_select.sv
sv/solid_color_texture_block_encoder_top.sv
tb/solid_color_texture_block_encoder_top_test.sv
